FILE: hdl/prl_pkg.sv
// ----------------------------------------------------------------------------
// prl_pkg: shared types and constants of the per-client request rate limiter
// Table geometry, key layout, opcode and register codes, ALU request/response.
// ----------------------------------------------------------------------------
package prl_pkg;

	// table geometry
	localparam int TABLE_ENTRIES = 1024;
	localparam int IDX_W         = $clog2(TABLE_ENTRIES);
	localparam logic [IDX_W-1:0] ENTRY_LAST   = IDX_W'(TABLE_ENTRIES - 1);
	localparam logic [IDX_W:0]   ENTRIES_EXT  = (IDX_W + 1)'(TABLE_ENTRIES);

	// field widths
	localparam int DATA_W = 32;
	localparam int RULE_W = 16;
	localparam int IP_W   = 32;
	localparam int KEY_W  = 1 + RULE_W + IP_W;

	// count written on a block (-10000)
	localparam logic [DATA_W-1:0] BLOCK_COUNT = 32'hFFFF_D8F0;

	// item opcodes
	localparam logic OP_REQUEST = 1'b0;
	localparam logic OP_CONNECT = 1'b1;

	// configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_DROP_MODE   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_ACTION_CODE = 1'b1;

	// one table slot as stored in the RAM
	typedef struct packed {
		logic              valid;
		logic [KEY_W-1:0]  key;
		logic [DATA_W-1:0] start_time;
		logic [DATA_W-1:0] count;
		logic [DATA_W-1:0] block_time;
	} slot_t;

	// shared ALU
	typedef enum logic {
		ALU_ADD,
		ALU_SUB
	} alu_op_t;

	typedef struct packed {
		alu_op_t           op;
		logic [DATA_W-1:0] a;
		logic [DATA_W-1:0] b;
	} alu_req_t;

	typedef struct packed {
		logic [DATA_W-1:0] res;
		logic              borrow;  // a < b (unsigned) for ALU_SUB
	} alu_rsp_t;

endpackage

FILE: hdl/prl_req_if.sv
// ----------------------------------------------------------------------------
// prl_req_if: input item channel of the rate limiter
// Valid/ready handshake carrying one request or connection check per beat.
// ----------------------------------------------------------------------------
interface prl_req_if;
	logic        valid;
	logic        ready;
	logic        opcode;
	logic [31:0] client_ip;
	logic [15:0] rule_number;
	logic [31:0] now_seconds;
	logic [15:0] window_seconds;
	logic [15:0] count_limit;
	logic [15:0] block_seconds;

	modport source (
		output valid, opcode, client_ip, rule_number, now_seconds,
		       window_seconds, count_limit, block_seconds,
		input  ready
	);
	modport sink (
		input  valid, opcode, client_ip, rule_number, now_seconds,
		       window_seconds, count_limit, block_seconds,
		output ready
	);
endinterface

FILE: hdl/prl_rsp_if.sv
// ----------------------------------------------------------------------------
// prl_rsp_if: result channel of the rate limiter
// Valid/ready handshake carrying one verdict per beat.
// ----------------------------------------------------------------------------
interface prl_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] verdict;

	modport source (output valid, verdict, input ready);
	modport sink (input valid, verdict, output ready);
endinterface

FILE: hdl/prl_ram.sv
// ----------------------------------------------------------------------------
// prl_ram: generic single-clock RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module prl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: hdl/prl_alu.sv
// ----------------------------------------------------------------------------
// prl_alu: shared 32-bit add/subtract unit
// One operation per cycle, result and borrow registered.
// ----------------------------------------------------------------------------
module prl_alu import prl_pkg::*; (
	input  logic     clk,
	input  alu_req_t req,
	output alu_rsp_t rsp
);

	logic [DATA_W-1:0] b_x;
	logic              cin;
	logic [DATA_W:0]   sum;
	alu_rsp_t          rsp_q;

	// a + b, or a + ~b + 1 for subtract
	always_comb begin
		case (req.op)
			ALU_SUB: begin
				b_x = ~req.b;
				cin = 1'b1;
			end
			default: begin
				b_x = req.b;
				cin = 1'b0;
			end
		endcase
		sum = {1'b0, req.a} + {1'b0, b_x} + (DATA_W + 1)'(cin);
	end

	always_ff @(posedge clk) begin
		rsp_q.res    <= sum[DATA_W-1:0];
		rsp_q.borrow <= (req.op == ALU_SUB) ? ~sum[DATA_W] : 1'b0;
	end

	assign rsp = rsp_q;

endmodule

FILE: hdl/per_client_request_rate_limiter.sv
// ----------------------------------------------------------------------------
// per_client_request_rate_limiter: fixed-window rate limiter with block timeout
// A request is looked up, counted and checked against its window, with one
//   more table read per extra probe; an expired window skips the limit
//   check, and a drop-mode block adds the address lookup and write. A
//   connection check skips the block-time test when the entry is absent.
//   One item at a time: the input reopens in the same cycle the verdict is
//   raised. After reset, and on a full table during a request, a clearing
//   sweep over all TABLE_ENTRIES (1024) slots runs with the input held off.
// ----------------------------------------------------------------------------
module per_client_request_rate_limiter import prl_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	prl_req_if.sink              req,
	prl_rsp_if.source            rsp,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]           cfg_wdata
);

	typedef enum logic [3:0] {
		S_CLR,
		S_IDLE,
		S_LK_RD,
		S_LK_CHK,
		S_R1,
		S_R2,
		S_R3,
		S_R4,
		S_R5,
		S_WR,
		S_C0,
		S_C1,
		S_C2,
		S_RESP
	} state_t;

	typedef enum logic [1:0] {
		PH_PAIR,
		PH_ADDR,
		PH_CONN
	} phase_t;

	// hash: fold the key onto the index bits, then wrap into the table
	function automatic logic [IDX_W-1:0] slot_hash(input logic [KEY_W-1:0] key);
		logic [IDX_W-1:0] h;
		logic [IDX_W:0]   hw;
		h = '0;
		for (int i = 0; i < KEY_W; i++) begin
			h[i % IDX_W] = h[i % IDX_W] ^ key[i];
		end
		hw = {1'b0, h};
		if (hw >= ENTRIES_EXT) begin
			hw = hw - ENTRIES_EXT;
		end
		return hw[IDX_W-1:0];
	endfunction

	state_t            state_q;
	phase_t            phase_q;
	logic [IDX_W-1:0]  clr_idx_q;
	logic              pend_q;
	logic              blocked_q;
	logic [KEY_W-1:0]  key_q;
	logic [IP_W-1:0]   ip_q;
	logic [DATA_W-1:0] now_q;
	logic [15:0]       win_q;
	logic [15:0]       limit_q;
	logic [15:0]       blk_q;
	logic [IDX_W-1:0]  probe_q;
	logic [IDX_W-1:0]  n_q;
	logic [IDX_W-1:0]  slot_q;
	logic [DATA_W-1:0] ent_start_q;
	logic [DATA_W-1:0] ent_count_q;
	logic [DATA_W-1:0] ent_block_q;
	logic [7:0]        verdict_q;
	logic              drop_mode_q;
	logic [7:0]        action_code_q;
	logic              rsp_valid_q;
	logic [7:0]        rsp_verdict_q;

	logic              accept;
	logic [KEY_W-1:0]  in_key;
	logic [KEY_W-1:0]  addr_key;
	logic              ram_we;
	logic [IDX_W-1:0]  ram_waddr;
	slot_t             ram_wdata;
	slot_t             rd_slot;
	logic              hit;
	alu_req_t          alu_req;
	alu_rsp_t          alu_rsp;

	assign accept   = req.valid && req.ready;
	assign in_key   = (req.opcode == OP_CONNECT) ?
	                  {1'b0, RULE_W'(0), req.client_ip} :
	                  {1'b1, req.rule_number, req.client_ip};
	assign addr_key = {1'b0, RULE_W'(0), ip_q};
	assign hit      = rd_slot.valid && (rd_slot.key == key_q);

	assign req.ready   = (state_q == S_IDLE);
	assign rsp.valid   = rsp_valid_q;
	assign rsp.verdict = rsp_verdict_q;

	// table RAM: clearing sweep or slot write-back
	always_comb begin
		ram_we    = (state_q == S_CLR) || (state_q == S_WR);
		ram_waddr = (state_q == S_CLR) ? clr_idx_q : slot_q;
		if (state_q == S_CLR) begin
			ram_wdata = '0;
		end else begin
			ram_wdata.valid      = 1'b1;
			ram_wdata.key        = key_q;
			ram_wdata.start_time = ent_start_q;
			ram_wdata.count      = ent_count_q;
			ram_wdata.block_time = ent_block_q;
		end
	end

	prl_ram #(
		.WIDTH($bits(slot_t)),
		.DEPTH(TABLE_ENTRIES)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (probe_q),
		.rdata (rd_slot)
	);

	// shared ALU operand selection per sequencer step
	always_comb begin
		alu_req.op = ALU_SUB;
		alu_req.a  = '0;
		alu_req.b  = '0;
		case (state_q)
			S_R1: begin
				alu_req.op = ALU_ADD;
				alu_req.a  = ent_count_q;
				alu_req.b  = DATA_W'(1);
			end
			S_R2, S_C0: begin
				alu_req.a = now_q;
				alu_req.b = ent_start_q;
			end
			S_R3: begin
				alu_req.a = DATA_W'(win_q);
				alu_req.b = alu_rsp.res;
			end
			S_R4: begin
				alu_req.a = DATA_W'(limit_q);
				alu_req.b = ent_count_q;
			end
			S_C1: begin
				alu_req.a = alu_rsp.res;
				alu_req.b = ent_block_q;
			end
			default: begin
				alu_req.a = '0;
			end
		endcase
	end

	prl_alu u_alu (
		.clk (clk),
		.req (alu_req),
		.rsp (alu_rsp)
	);

	// sequencer, configuration registers and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_CLR;
			phase_q       <= PH_PAIR;
			clr_idx_q     <= '0;
			pend_q        <= 1'b0;
			blocked_q     <= 1'b0;
			drop_mode_q   <= 1'b0;
			action_code_q <= 8'd1;
			rsp_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_DROP_MODE:   drop_mode_q   <= cfg_wdata[0];
					REG_ACTION_CODE: action_code_q <= cfg_wdata;
				endcase
			end

			// result beat taken; the response step reloads it itself
			if (rsp_valid_q && rsp.ready && state_q != S_RESP) begin
				rsp_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_CLR: begin
					// index wraps back to zero after the last slot
					clr_idx_q <= clr_idx_q + 1'b1;
					if (clr_idx_q == ENTRY_LAST) begin
						pend_q    <= 1'b0;
						state_q   <= pend_q ? S_RESP : S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						ip_q    <= req.client_ip;
						now_q   <= req.now_seconds;
						win_q   <= req.window_seconds;
						limit_q <= req.count_limit;
						blk_q   <= req.block_seconds;
						key_q   <= in_key;
						probe_q <= slot_hash(in_key);
						n_q     <= '0;
						phase_q <= (req.opcode == OP_CONNECT) ? PH_CONN : PH_PAIR;
						state_q <= S_LK_RD;
					end
				end
				S_LK_RD: begin
					state_q <= S_LK_CHK;
				end
				S_LK_CHK: begin
					if (hit || !rd_slot.valid) begin
						// found the key, or the first free slot on its probe path;
						// the address mark takes the new start and block length
						slot_q      <= probe_q;
						ent_start_q <= (phase_q == PH_ADDR) ? now_q :
						               (hit ? rd_slot.start_time : '0);
						ent_count_q <= hit ? rd_slot.count : '0;
						ent_block_q <= (phase_q == PH_ADDR) ? DATA_W'(blk_q) :
						               (hit ? rd_slot.block_time : '0);
						unique case (phase_q)
							PH_PAIR: state_q <= S_R1;
							PH_ADDR: begin
								verdict_q   <= action_code_q;
								state_q     <= S_WR;
							end
							PH_CONN: begin
								verdict_q <= '0;
								state_q   <= hit ? S_C0 : S_RESP;
							end
							default: state_q <= S_RESP;
						endcase
					end else if (n_q == ENTRY_LAST) begin
						// every slot probed: table full
						verdict_q <= '0;
						if (phase_q == PH_PAIR) begin
							pend_q    <= 1'b1;
							clr_idx_q <= '0;
							state_q   <= S_CLR;
						end else begin
							state_q <= S_RESP;
						end
					end else begin
						probe_q <= (probe_q == ENTRY_LAST) ? '0 : probe_q + 1'b1;
						n_q     <= n_q + 1'b1;
						state_q <= S_LK_RD;
					end
				end
				S_R1: begin
					if (ent_start_q == '0) begin
						ent_start_q <= now_q;
					end
					state_q <= S_R2;
				end
				S_R2: begin
					ent_count_q <= alu_rsp.res;
					state_q     <= S_R3;
				end
				S_R3: begin
					state_q <= S_R4;
				end
				S_R4: begin
					// window expired: restart it
					if (alu_rsp.borrow) begin
						ent_start_q <= now_q;
						ent_count_q <= '0;
						verdict_q   <= '0;
						blocked_q   <= 1'b0;
						state_q     <= S_WR;
					end else begin
						state_q <= S_R5;
					end
				end
				S_R5: begin
					// count above limit: block
					if (!ent_count_q[DATA_W-1] && alu_rsp.borrow) begin
						ent_start_q <= now_q;
						ent_count_q <= BLOCK_COUNT;
						if (!drop_mode_q) begin
							ent_block_q <= DATA_W'(blk_q);
						end
						verdict_q <= drop_mode_q ? 8'd0 : action_code_q;
						blocked_q <= drop_mode_q;
					end else begin
						verdict_q <= '0;
						blocked_q <= 1'b0;
					end
					state_q <= S_WR;
				end
				S_WR: begin
					if (blocked_q) begin
						// drop mode: mark the bare address entry next
						blocked_q <= 1'b0;
						key_q     <= addr_key;
						probe_q   <= slot_hash(addr_key);
						n_q       <= '0;
						phase_q   <= PH_ADDR;
						state_q   <= S_LK_RD;
					end else begin
						state_q <= S_RESP;
					end
				end
				S_C0: begin
					state_q <= S_C1;
				end
				S_C1: begin
					state_q <= S_C2;
				end
				S_C2: begin
					verdict_q <= alu_rsp.borrow ? action_code_q : 8'd0;
					state_q   <= S_RESP;
				end
				S_RESP: begin
					if (!rsp_valid_q || rsp.ready) begin
						rsp_valid_q   <= 1'b1;
						rsp_verdict_q <= verdict_q;
						state_q       <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// an accepted beat starts a multi-cycle item
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !req.ready)
		else $error("input ready right after an accepted beat");

	// only the clearing sweep writes invalid slots
	a_write_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && state_q != S_CLR) |-> ram_wdata.valid)
		else $error("slot write-back without valid bit");

	// a new result beat comes only from the response step
	a_rsp_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == S_RESP))
		else $error("result raised outside response step");

	// each further probe advances the probe count by one
	a_probe_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LK_RD && $past(state_q) == S_LK_CHK) |->
			(n_q == $past(n_q) + 1'b1))
		else $error("probe count did not advance");

endmodule
